// ----- hdl/cfta_pkg.sv -----
// ----------------------------------------------------------------------------
// cfta_pkg
// Types, constants and the byte-wide CRC-16/MODBUS update shared by the
// frame trailer appender.
// ----------------------------------------------------------------------------
package cfta_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  FORCED_FIRST = 8'h01;
   localparam logic [1:0]  POS_MAX      = 2'd3;

   // mode register codes; the unused code behaves as pass-through
   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_LENGTH = 2'd1;
   localparam logic [1:0] MODE_FORCE  = 2'd2;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // one classified body byte travelling from front to back
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } body_entry_type;

   typedef enum logic [1:0] {
      ST_BODY,
      ST_CRC_LO,
      ST_CRC_HI
   } back_state_type;

   // reflected CRC-16 update by one byte, unrolled over eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

// ----- hdl/cfta_front.sv -----
// ----------------------------------------------------------------------------
// cfta_front
// Accepts body bytes, tracks the position within the frame, holds the
// mode register and applies length insertion or first-byte forcing.
// ----------------------------------------------------------------------------
module cfta_front
   import cfta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic [1:0]     csr_write_data,
   input  logic           accept,
   input  logic [7:0]     body_byte,
   input  logic           last_body_byte,
   input  logic [15:0]    body_length,
   output body_entry_type entry
);

   logic [1:0]  mode_ff;
   logic [1:0]  pos_ff;
   logic [1:0]  pos_in;
   logic [15:0] held_length_ff;
   logic [15:0] held_length_in;
   logic [15:0] len_src;
   logic [15:0] len_m1;
   logic [7:0]  byte_out;

   always_comb begin
      len_src  = (pos_ff == 2'd0) ? body_length : held_length_ff;
      len_m1   = len_src - 16'd1;
      byte_out = body_byte;
      case (mode_ff)
         MODE_LENGTH: begin
            if (pos_ff == 2'd1) begin
               byte_out = len_m1[15:8];
            end else if (pos_ff == 2'd2) begin
               byte_out = len_m1[7:0];
            end
         end
         MODE_FORCE: begin
            if (pos_ff == 2'd0) begin
               byte_out = FORCED_FIRST;
            end
         end
         default: begin
            byte_out = body_byte;
         end
      endcase
      entry.tx_byte = byte_out;
      entry.last    = last_body_byte;
   end

   always_comb begin
      pos_in         = pos_ff;
      held_length_in = held_length_ff;
      if (accept) begin
         if (pos_ff == 2'd0) begin
            held_length_in = body_length;
         end
         if (last_body_byte) begin
            pos_in = 2'd0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PASS;
         pos_ff         <= 2'd0;
         held_length_ff <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         pos_ff         <= pos_in;
         held_length_ff <= held_length_in;
      end
   end

endmodule

// ----- hdl/cfta_queue.sv -----
// ----------------------------------------------------------------------------
// cfta_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cfta_queue
   import cfta_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  body_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output body_entry_type pop_entry,
   output logic           empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   body_entry_type slot_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff;
   logic [AW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/cfta_back.sv -----
// ----------------------------------------------------------------------------
// cfta_back
// Drains classified bytes, runs the CRC and appends the two trailer bytes
// through a one-entry output register.
// ----------------------------------------------------------------------------
module cfta_back
   import cfta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  body_entry_type q_entry,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [7:0]     rsp_tx_byte,
   output logic           rsp_frame_end
);

   back_state_type state_ff;
   back_state_type state_in;
   logic [15:0]    crc_ff;
   logic [15:0]    crc_in;
   logic [15:0]    crc_next;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [7:0]     out_byte_ff;
   logic [7:0]     out_byte_in;
   logic           out_end_ff;
   logic           out_end_in;
   logic           advance;

   assign rsp_empty     = !out_valid_ff;
   assign rsp_tx_byte   = out_byte_ff;
   assign rsp_frame_end = out_end_ff;
   assign advance       = !out_valid_ff || rsp_pop;
   assign crc_next      = crc_byte(crc_ff, q_entry.tx_byte);

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      q_pop        = 1'b0;
      if (advance) begin
         case (state_ff)
            ST_BODY: begin
               if (!q_empty) begin
                  q_pop        = 1'b1;
                  crc_in       = crc_next;
                  out_valid_in = 1'b1;
                  out_byte_in  = q_entry.tx_byte;
                  out_end_in   = 1'b0;
                  if (q_entry.last) begin
                     state_in = ST_CRC_LO;
                  end
               end
            end
            ST_CRC_LO: begin
               out_valid_in = 1'b1;
               out_byte_in  = crc_ff[7:0];
               out_end_in   = 1'b0;
               state_in     = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               // close the frame and start a fresh CRC
               out_valid_in = 1'b1;
               out_byte_in  = crc_ff[15:8];
               out_end_in   = 1'b1;
               crc_in       = CRC_INIT;
               state_in     = ST_BODY;
            end
            default: begin
               state_in = ST_BODY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BODY;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hdl/crc16_frame_trailer_appender_unit.sv -----
// A body byte is held in the front-to-back queue of QUEUE_DEPTH, then in the
// output register. Throughput: one body byte per cycle in unless req_full, one
// result byte per cycle out while popped; the queue absorbs the CRC low and
// high bytes that follow the last body byte of a frame.
// Reset: synchronous; mode returns to pass-through, CRC to 0xFFFF, queue empty.
// ----------------------------------------------------------------------------
// crc16_frame_trailer_appender_unit
// Passes frame body bytes with optional header rewriting and appends the
// CRC-16/MODBUS trailer, low byte first.
// ----------------------------------------------------------------------------
module crc16_frame_trailer_appender_unit
   import cfta_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_body_byte,
   input  logic        req_last_body_byte,
   input  logic [15:0] req_body_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_frame_end
);

   logic           accept;
   body_entry_type front_entry;
   body_entry_type q_entry;
   logic           q_empty;
   logic           q_pop;

   assign accept = req_push && !req_full;

   cfta_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .body_byte        (req_body_byte),
      .last_body_byte   (req_last_body_byte),
      .body_length      (req_body_length),
      .entry            (front_entry)
   );

   cfta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (req_full),
      .pop        (q_pop),
      .pop_entry  (q_entry),
      .empty      (q_empty)
   );

   cfta_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-16/MODBUS frame trailer appender. A table of
// directed frames walks every mode, header rewrite and length corner, then
// random frames with random gaps on both sides, mid-frame mode changes and a
// long receiver stall. Every result transfer is checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top
   import cfta_pkg::*;
;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         HOLD_CYCLES    = 40;
   localparam int         WATCHDOG_LIMIT = 600;
   localparam int         RANDOM_ITEMS   = 150;
   localparam int         PRINT_LIMIT    = 50;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
   } tx_expect_type;

   typedef enum logic {
      ROW_MODE,
      ROW_BYTE
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   mode;
      logic [7:0]   data;
      logic         last;
      logic [15:0]  length;
      logic         chk_byte;
      logic [7:0]   exp_byte;
      logic         chk_crc;
      logic [15:0]  exp_crc;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_body_byte;
   logic        req_last_body_byte;
   logic [15:0] req_body_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_frame_end;

   // typed-in expectations travelling alongside the item
   logic        note_chk_byte;
   logic [7:0]  note_byte;
   logic        note_chk_crc;
   logic [15:0] note_crc;

   // predictor state
   logic [1:0]    model_mode;
   logic [15:0]   model_crc;
   logic [1:0]    model_pos;
   logic [15:0]   model_len;
   tx_expect_type tx_expect_q[$];

   int error_count   = 0;
   bit hold_request  = 1'b0;
   int rsp_gap_max   = 3;

   crc16_frame_trailer_appender_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_body_byte      (req_body_byte),
      .req_last_body_byte (req_last_body_byte),
      .req_body_length    (req_body_length),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // reflected update, one data bit at a time
   function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ data[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("tb_top: %s mismatch: got %0h want %0h at %0t", what, got, want, $realtime);
      end
      error_count++;
   endtask

   task automatic predict_tx_bytes(input logic [7:0] data, input logic last,
                                   input logic [15:0] len, input logic chk_b,
                                   input logic [7:0] exp_b, input logic chk_c,
                                   input logic [15:0] exp_c);
      logic [7:0]  b;
      logic [15:0] len_m1;
      logic [15:0] crc_out;
      b = data;
      if (model_pos == 2'd0) begin
         model_len = len;
      end
      len_m1 = model_len - 16'd1;
      case (model_mode)
         MODE_LENGTH: begin
            if (model_pos == 2'd1) begin
               b = len_m1[15:8];
            end else if (model_pos == 2'd2) begin
               b = len_m1[7:0];
            end
         end
         MODE_FORCE: begin
            if (model_pos == 2'd0) begin
               b = FORCED_FIRST;
            end
         end
         default: begin
         end
      endcase
      model_crc = crc16_update(model_crc, b);
      tx_expect_q.push_back('{chk_b ? exp_b : b, 1'b0});
      if (!last) begin
         if (model_pos != POS_MAX) begin
            model_pos = model_pos + 2'd1;
         end
      end else begin
         crc_out = chk_c ? exp_c : model_crc;
         tx_expect_q.push_back('{crc_out[7:0], 1'b0});
         tx_expect_q.push_back('{crc_out[15:8], 1'b1});
         model_crc = CRC_INIT;
         model_pos = 2'd0;
      end
   endtask

   // monitor: predict on input transfers, check on result transfers
   always @(posedge clock) begin
      tx_expect_type e;
      if (reset) begin
         model_mode = MODE_PASS;
         model_crc  = CRC_INIT;
         model_pos  = 2'd0;
         model_len  = 16'd0;
         tx_expect_q.delete();
      end else begin
         if (req_push && !req_full) begin
            predict_tx_bytes(req_body_byte, req_last_body_byte, req_body_length,
                             note_chk_byte, note_byte, note_chk_crc, note_crc);
         end
         if (rsp_pop && !rsp_empty) begin
            if (tx_expect_q.size() == 0) begin
               report_mismatch("unexpected result tx_byte", {8'h00, rsp_tx_byte}, 16'd0);
            end else begin
               e = tx_expect_q.pop_front();
               if (rsp_tx_byte !== e.tx_byte) begin
                  report_mismatch("tx_byte", {8'h00, rsp_tx_byte}, {8'h00, e.tx_byte});
               end
               if (rsp_frame_end !== e.frame_end) begin
                  report_mismatch("frame_end", {15'd0, rsp_frame_end},
                                  {15'd0, e.frame_end});
               end
            end
         end
         if (csr_write_enable) begin
            model_mode = csr_write_data;
         end
      end
   end

   // hold the sender until every expected result has been popped
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (tx_expect_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_item(input logic [7:0] data, input logic last,
                            input logic [15:0] len, input logic chk_b,
                            input logic [7:0] exp_b, input logic chk_c,
                            input logic [15:0] exp_c, input int gap_max);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push           <= 1'b1;
      req_body_byte      <= data;
      req_last_body_byte <= last;
      req_body_length    <= len;
      note_chk_byte      <= chk_b;
      note_byte          <= exp_b;
      note_chk_crc       <= chk_c;
      note_crc           <= exp_c;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   function automatic stim_row_type byte_row(input logic [7:0] data, input logic last,
                                             input logic [15:0] len, input logic chk_b,
                                             input logic [7:0] exp_b,
                                             input logic chk_c = 1'b0,
                                             input logic [15:0] exp_c = 16'd0);
      return '{ROW_BYTE, MODE_PASS, data, last, len, chk_b, exp_b, chk_c, exp_c};
   endfunction

   function automatic stim_row_type mode_row(input logic [1:0] mode);
      return '{ROW_MODE, mode, 8'd0, 1'b0, 16'd0, 1'b0, 8'd0, 1'b0, 16'd0};
   endfunction

   // receiver: random pops, with one long hold-off on request
   initial begin
      int gap;
      rsp_pop <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // watchdog: end the run if nothing transfers for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      int           items_sent;
      int           frame_no;
      int           flen;
      int           gap_max;
      logic [15:0]  blen;

      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= MODE_PASS;
      req_push           <= 1'b0;
      req_body_byte      <= 8'd0;
      req_last_body_byte <= 1'b0;
      req_body_length    <= 16'd0;
      note_chk_byte      <= 1'b0;
      note_byte          <= 8'd0;
      note_chk_crc       <= 1'b0;
      note_crc           <= 16'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pass-through straight after reset: a textbook request frame, then
      // a single-byte frame
      rows.push_back(byte_row(8'h01, 1'b0, 16'd6, 1'b1, 8'h01));
      rows.push_back(byte_row(8'h03, 1'b0, 16'd0, 1'b1, 8'h03));
      rows.push_back(byte_row(8'h00, 1'b0, 16'd0, 1'b1, 8'h00));
      rows.push_back(byte_row(8'h00, 1'b0, 16'd0, 1'b1, 8'h00));
      rows.push_back(byte_row(8'h00, 1'b0, 16'd0, 1'b1, 8'h00));
      rows.push_back(byte_row(8'h01, 1'b1, 16'd0, 1'b1, 8'h01, 1'b1, 16'h0A84));
      rows.push_back(byte_row(8'hFF, 1'b1, 16'hFFFF, 1'b1, 8'hFF));
      // length insertion: zero length wraps, a short frame, the largest length
      rows.push_back(mode_row(MODE_LENGTH));
      rows.push_back(byte_row(8'hAA, 1'b0, 16'd0, 1'b1, 8'hAA));
      rows.push_back(byte_row(8'hBB, 1'b0, 16'h1234, 1'b1, 8'hFF));
      rows.push_back(byte_row(8'hCC, 1'b0, 16'h1234, 1'b1, 8'hFF));
      rows.push_back(byte_row(8'hDD, 1'b1, 16'h1234, 1'b1, 8'hDD));
      rows.push_back(byte_row(8'h55, 1'b1, 16'd2, 1'b1, 8'h55));
      rows.push_back(byte_row(8'h00, 1'b0, 16'hFFFF, 1'b1, 8'h00));
      rows.push_back(byte_row(8'h00, 1'b0, 16'd0, 1'b1, 8'hFF));
      rows.push_back(byte_row(8'h00, 1'b1, 16'd0, 1'b1, 8'hFE));
      // forced first byte, then the unused code as pass-through
      rows.push_back(mode_row(MODE_FORCE));
      rows.push_back(byte_row(8'hFF, 1'b0, 16'd5, 1'b1, 8'h01));
      rows.push_back(byte_row(8'h80, 1'b1, 16'd0, 1'b1, 8'h80));
      rows.push_back(mode_row(MODE_UNUSED));
      rows.push_back(byte_row(8'hA5, 1'b0, 16'd2, 1'b1, 8'hA5));
      rows.push_back(byte_row(8'h5A, 1'b1, 16'd0, 1'b1, 8'h5A));
      // mode changed between bytes of one frame
      rows.push_back(mode_row(MODE_PASS));
      rows.push_back(byte_row(8'h7E, 1'b0, 16'd3, 1'b1, 8'h7E));
      rows.push_back(mode_row(MODE_LENGTH));
      rows.push_back(byte_row(8'h11, 1'b0, 16'd0, 1'b1, 8'h00));
      rows.push_back(mode_row(MODE_FORCE));
      rows.push_back(byte_row(8'h22, 1'b0, 16'd0, 1'b1, 8'h22));
      rows.push_back(byte_row(8'h33, 1'b1, 16'd0, 1'b1, 8'h33));

      foreach (rows[k]) begin
         if (rows[k].kind == ROW_MODE) begin
            write_mode(rows[k].mode);
         end else begin
            send_item(rows[k].data, rows[k].last, rows[k].length, rows[k].chk_byte,
                      rows[k].exp_byte, rows[k].chk_crc, rows[k].exp_crc, 3);
         end
      end

      items_sent = 0;
      frame_no   = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            write_mode(2'($urandom_range(0, 3)));
         end
         flen        = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                  : $urandom_range(7, 20);
         gap_max     = ($urandom_range(0, 2) == 0) ? 0 : 3;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
         if (frame_no == 4) begin
            // stall the receiver and keep offering until the block backs up
            hold_request = 1'b1;
            flen         = 24;
            gap_max      = 0;
         end
         if (frame_no == 10) begin
            drain_results();
         end
         blen = ($urandom_range(0, 3) != 0) ? 16'(flen) : 16'($urandom_range(0, 65535));
         for (int i = 0; i < flen; i++) begin
            if (i > 0 && $urandom_range(0, 29) == 0) begin
               write_mode(2'($urandom_range(0, 3)));
            end
            send_item(8'($urandom_range(0, 255)), i == flen - 1,
                      (i == 0) ? blen : 16'($urandom_range(0, 65535)),
                      1'b0, 8'd0, 1'b0, 16'd0, gap_max);
            items_sent++;
         end
         frame_no++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/cfta_pkg.sv
hdl/cfta_front.sv
hdl/cfta_queue.sv
hdl/cfta_back.sv
hdl/crc16_frame_trailer_appender_unit.sv
verif/tb_top.sv
